[hdl/scl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scl_pkg
// Shared types and constants of the scan collision speed limiter.
// ----------------------------------------------------------------------------
package scl_pkg;

  // Point coordinate width, 1/1024 m per step.
  localparam int unsigned CoordWidth = 16;
  // Width of one squared coordinate and of the corridor compare.
  localparam int unsigned SqWidth    = 2 * CoordWidth;
  localparam int unsigned CmpWidth   = ((CoordWidth > 16) ? CoordWidth : 16) + 1;

  localparam int unsigned DistWidth  = 32;
  localparam int unsigned RegWidth   = 15;
  localparam int unsigned VelWidth   = 16;
  localparam int unsigned WheelWidth = 20;

  localparam logic [RegWidth-1:0] StopRadiusReset   = 15'd1024;
  localparam logic [RegWidth-1:0] CorridorHalfReset = 15'd205;

  // Command queue between the classifier and the speed unit.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  // ceil(2^32 / 100); exact for wheel numerators below 2^26.
  localparam logic [25:0] WheelRecip = 26'd42949673;

  typedef enum logic [1:0] {
    OpPoint    = 2'd0,
    OpEndCloud = 2'd1,
    OpVelocity = 2'd2,
    OpJoystick = 2'd3
  } op_e;

  typedef enum logic [0:0] {
    CfgStopRadius   = 1'b0,
    CfgCorridorHalf = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    op_e                           operation;
    logic signed [CoordWidth-1:0]  point_x;
    logic signed [CoordWidth-1:0]  point_y;
    logic signed [VelWidth-1:0]    lin_velocity;
    logic signed [VelWidth-1:0]    ang_velocity;
  } in_item_t;

  typedef struct packed {
    logic signed [VelWidth-1:0]   out_linear;
    logic signed [VelWidth-1:0]   out_angular;
    logic signed [WheelWidth-1:0] left_wheel;
    logic signed [WheelWidth-1:0] right_wheel;
  } out_item_t;

  // A classified command: speeds and the committed distance on its side.
  typedef struct packed {
    logic signed [VelWidth-1:0] lin;
    logic signed [VelWidth-1:0] ang;
    logic [DistWidth-1:0]       dist_sq;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

[hdl/scl_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scl_front
// Accepts items, tracks the corridor minima and classifies commands.
// ----------------------------------------------------------------------------
module scl_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  scl_pkg::in_item_t                 in_item_i,
  input  logic [scl_pkg::RegWidth-1:0]      corridor_half_width_i,
  input  scl_pkg::queue_status_t            queue_status_i,
  output logic                              push_o,
  output scl_pkg::cmd_t                     cmd_o
);

  localparam int unsigned CW   = scl_pkg::CoordWidth;
  localparam int unsigned SqW  = scl_pkg::SqWidth;
  localparam int unsigned CmpW = scl_pkg::CmpWidth;
  localparam int unsigned DW   = scl_pkg::DistWidth;
  localparam int unsigned VW   = scl_pkg::VelWidth;
  localparam int unsigned ExtW = (SqW > DW) ? SqW : DW + 1;

  logic                   s1_valid_q;
  scl_pkg::op_e           s1_op_q;
  logic [SqW-1:0]         sq_x_q, sq_y_q;
  logic                   s1_counts_q, s1_ahead_q;
  logic signed [VW-1:0]   s1_lin_q, s1_ang_q;

  logic [DW-1:0] ahead_bld_q, behind_bld_q, ahead_cmt_q, behind_cmt_q;

  logic                   adv;
  logic signed [SqW-1:0]  prod_x, prod_y;
  logic signed [CmpW-1:0] y_ext, h_ext;
  logic signed [VW-1:0]   lin_adj, lin_half;
  logic                   is_cmd;
  logic [ExtW-1:0]        sum_ext;
  logic [DW-1:0]          pt_dist;

  assign is_cmd = (s1_op_q == scl_pkg::OpVelocity) || (s1_op_q == scl_pkg::OpJoystick);
  // The only back pressure is a command waiting on a full queue.
  assign adv        = !(s1_valid_q && is_cmd && queue_status_i.full);
  assign in_stall_o = !adv;

  always_comb begin
    prod_x   = in_item_i.point_x * in_item_i.point_x;
    prod_y   = in_item_i.point_y * in_item_i.point_y;
    y_ext    = CmpW'(in_item_i.point_y);
    h_ext    = $signed(CmpW'(corridor_half_width_i));
    // Joystick halving truncates toward zero.
    lin_adj  = in_item_i.lin_velocity + $signed({{(VW-1){1'b0}}, in_item_i.lin_velocity[VW-1]});
    lin_half = lin_adj >>> 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      s1_op_q     <= in_item_i.operation;
      sq_x_q      <= $unsigned(prod_x);
      sq_y_q      <= $unsigned(prod_y);
      s1_counts_q <= (y_ext > -h_ext) && (y_ext < h_ext) && (in_item_i.point_x != '0);
      s1_ahead_q  <= !in_item_i.point_x[CW-1];
      s1_lin_q    <= (in_item_i.operation == scl_pkg::OpJoystick) ? lin_half
                                                                  : in_item_i.lin_velocity;
      s1_ang_q    <= in_item_i.ang_velocity;
    end
  end

  always_comb begin
    sum_ext = ExtW'(sq_x_q) + ExtW'(sq_y_q);
    pt_dist = (|sum_ext[ExtW-1:DW]) ? '1 : sum_ext[DW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ahead_bld_q  <= '1;
      behind_bld_q <= '1;
      ahead_cmt_q  <= '1;
      behind_cmt_q <= '1;
    end else if (s1_valid_q && adv) begin
      case (s1_op_q)
        scl_pkg::OpPoint: begin
          if (s1_counts_q) begin
            if (s1_ahead_q) begin
              if (pt_dist < ahead_bld_q) ahead_bld_q <= pt_dist;
            end else begin
              if (pt_dist < behind_bld_q) behind_bld_q <= pt_dist;
            end
          end
        end
        scl_pkg::OpEndCloud: begin
          ahead_cmt_q  <= ahead_bld_q;
          behind_cmt_q <= behind_bld_q;
          ahead_bld_q  <= '1;
          behind_bld_q <= '1;
        end
        default: begin
        end
      endcase
    end
  end

  // Commands take the committed minimum here, in stream order with the commits.
  always_comb begin
    push_o      = s1_valid_q && is_cmd && adv;
    cmd_o.lin   = s1_lin_q;
    cmd_o.ang   = s1_ang_q;
    if (s1_lin_q > 0) begin
      cmd_o.dist_sq = ahead_cmt_q;
    end else if (s1_lin_q < 0) begin
      cmd_o.dist_sq = behind_cmt_q;
    end else begin
      cmd_o.dist_sq = '1;
    end
  end

endmodule

[hdl/scl_cmd_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scl_cmd_queue
// Short first-in first-out queue of classified commands.
// ----------------------------------------------------------------------------
module scl_cmd_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  scl_pkg::cmd_t          data_i,
  input  logic                   pop_i,
  output scl_pkg::cmd_t          data_o,
  output scl_pkg::queue_status_t status_o
);

  localparam int unsigned Depth = scl_pkg::QueueDepth;
  localparam int unsigned PtrW  = scl_pkg::QueuePtrW;

  scl_pkg::cmd_t   entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   count_q;

  assign status_o.full  = (count_q == (PtrW+1)'(Depth));
  assign status_o.empty = (count_q == '0);
  assign data_o         = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= data_i;
  end

endmodule

[hdl/scl_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scl_back
// Speed unit: stop, divide or pass, then twist and wheel speeds.
// ----------------------------------------------------------------------------
module scl_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  scl_pkg::queue_status_t        queue_status_i,
  input  scl_pkg::cmd_t                 cmd_i,
  output logic                          pop_o,
  input  logic [scl_pkg::RegWidth-1:0]  stop_radius_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output scl_pkg::out_item_t            out_item_o
);

  localparam int unsigned VW       = scl_pkg::VelWidth;
  localparam int unsigned DW       = scl_pkg::DistWidth;
  localparam int unsigned RW       = scl_pkg::RegWidth;
  localparam int unsigned WW       = scl_pkg::WheelWidth;
  localparam int unsigned NumW     = VW + 20;         // |v| * 2^20
  localparam int unsigned DiffW    = DW + 2;
  localparam int unsigned DenW     = DiffW + 10;      // 1000 * diff, signed
  localparam int unsigned DmagW    = DenW - 1;
  localparam int unsigned DivSteps = NumW;
  localparam int unsigned CntW     = $clog2(DivSteps);
  localparam int unsigned NW       = 27;              // wheel numerator, signed
  localparam int unsigned MagW     = NW - 1;
  localparam int unsigned ProdW    = MagW + 26;

  typedef enum logic [2:0] {
    StIdle, StCalc1, StCalc2, StDivide, StDivDone, StWheel1, StWheel2, StEmit
  } state_e;

  state_e                state_q;
  logic signed [VW-1:0]  v_q, w_q;
  logic [DW-1:0]         c_q;
  logic [2*RW-1:0]       r2_q;
  logic signed [DiffW-1:0] diff_q;
  logic [DmagW-1:0]      dmag_q;
  logic [DmagW-1:0]      rem_q;
  logic [NumW-1:0]       quo_q;
  logic [CntW-1:0]       cnt_q;
  logic                  neg_q;
  logic signed [NW-1:0]  nl_q, nr_q;
  logic [WW-1:0]         ql_q, qr_q;
  logic                  negl_q, negr_q;
  logic                  out_valid_q;
  scl_pkg::out_item_t    out_q;

  logic [DW-1:0]         three_r2;
  logic signed [DenW-1:0] den;
  logic [DenW-1:0]       den_mag;
  logic [VW-1:0]         v_mag;
  logic [DmagW:0]        trial;
  logic                  fits;
  logic signed [VW-1:0]  v_sat;
  logic [NW-1:0]         magl_full, magr_full;
  logic [ProdW-1:0]      prod_l, prod_r;
  logic                  slot_free;

  assign pop_o       = (state_q == StIdle) && !queue_status_i.empty;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign slot_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    three_r2 = DW'(r2_q) + DW'({r2_q, 1'b0});
    den      = DenW'(diff_q) * $signed(DenW'(1000));
    den_mag  = den[DenW-1] ? DenW'(-den) : DenW'(den);
    v_mag    = v_q[VW-1] ? VW'(-v_q) : VW'(v_q);
    trial    = {rem_q, quo_q[NumW-1]};
    fits     = (trial >= {1'b0, dmag_q});
    if (neg_q) begin
      v_sat = (quo_q > NumW'(32768)) ? $signed(VW'(16'h8000)) : $signed(VW'(-quo_q));
    end else begin
      v_sat = (quo_q > NumW'(32767)) ? $signed(VW'(16'h7fff)) : $signed(quo_q[VW-1:0]);
    end
    magl_full = nl_q[NW-1] ? NW'(-nl_q) : NW'(nl_q);
    magr_full = nr_q[NW-1] ? NW'(-nr_q) : NW'(nr_q);
    prod_l    = ProdW'(magl_full[MagW-1:0]) * ProdW'(scl_pkg::WheelRecip);
    prod_r    = ProdW'(magr_full[MagW-1:0]) * ProdW'(scl_pkg::WheelRecip);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == StEmit) && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (!queue_status_i.empty) begin
            v_q     <= cmd_i.lin;
            w_q     <= cmd_i.ang;
            c_q     <= cmd_i.dist_sq;
            state_q <= StCalc1;
          end
        end
        StCalc1: begin
          r2_q    <= stop_radius_i * stop_radius_i;
          diff_q  <= $signed({2'b00, c_q}) - $signed({{(DiffW-RW-10){1'b0}}, stop_radius_i, 10'b0});
          state_q <= StCalc2;
        end
        StCalc2: begin
          if (c_q < DW'(r2_q)) begin
            v_q     <= '0;
            state_q <= StWheel1;
          end else if (c_q < three_r2) begin
            if (diff_q == '0) begin
              v_q     <= '0;
              state_q <= StWheel1;
            end else begin
              dmag_q  <= den_mag[DmagW-1:0];
              neg_q   <= v_q[VW-1] ^ den[DenW-1];
              rem_q   <= '0;
              quo_q   <= {v_mag, 20'b0};
              cnt_q   <= CntW'(DivSteps - 1);
              state_q <= StDivide;
            end
          end else begin
            state_q <= StWheel1;
          end
        end
        StDivide: begin
          // Restoring division, one quotient bit per cycle.
          rem_q <= fits ? DmagW'(trial - {1'b0, dmag_q}) : trial[DmagW-1:0];
          quo_q <= {quo_q[NumW-2:0], fits};
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) state_q <= StDivDone;
        end
        StDivDone: begin
          v_q     <= v_sat;
          state_q <= StWheel1;
        end
        StWheel1: begin
          nl_q    <= NW'(v_q) * $signed(NW'(1000)) - NW'(w_q) * $signed(NW'(165));
          nr_q    <= NW'(v_q) * $signed(NW'(1000)) + NW'(w_q) * $signed(NW'(165));
          state_q <= StWheel2;
        end
        StWheel2: begin
          // Magnitudes stay below 2^26, so the quotients never reach the rails.
          ql_q    <= prod_l[ProdW-1 -: WW];
          qr_q    <= prod_r[ProdW-1 -: WW];
          negl_q  <= nl_q[NW-1];
          negr_q  <= nr_q[NW-1];
          state_q <= StEmit;
        end
        StEmit: begin
          if (slot_free) begin
            out_q.out_linear  <= v_q;
            out_q.out_angular <= w_q;
            out_q.left_wheel  <= negl_q ? $signed(WW'(-ql_q)) : $signed(ql_q);
            out_q.right_wheel <= negr_q ? $signed(WW'(-qr_q)) : $signed(qr_q);
            state_q           <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

[hdl/scan_collision_speed_limiter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scan_collision_speed_limiter
// Corridor obstacle minima from scan points; speed limiting of commands.
//
//   channel  direction  handshake                   payload
//   in       input      in_valid_i / in_stall_o     scl_pkg::in_item_t
//   out      output     out_valid_o / out_stall_i   scl_pkg::out_item_t
//   cfg      input      cfg_valid_i / cfg_ready_o   cfg_index_i, cfg_data_i
//
// Scan points and end-of-cloud items are taken one per cycle while the input is not stalled.
// The speed unit takes one command at a time, through the 36-step restoring
// divider when it scales the speed; a four-entry queue absorbs bursts of commands.
// The input stalls only when a command meets a full queue.
// Reset sets all minima to all ones and the registers to 1024 and 205.
// ----------------------------------------------------------------------------
module scan_collision_speed_limiter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  scl_pkg::in_item_t             in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output scl_pkg::out_item_t            out_item_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [0:0]                    cfg_index_i,
  input  logic [scl_pkg::RegWidth-1:0]  cfg_data_i
);

  logic [scl_pkg::RegWidth-1:0] stop_radius_q, corridor_half_width_q;
  logic                         q_push, q_pop;
  scl_pkg::cmd_t                q_wdata, q_rdata;
  scl_pkg::queue_status_t       q_status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_radius_q         <= scl_pkg::StopRadiusReset;
      corridor_half_width_q <= scl_pkg::CorridorHalfReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (scl_pkg::cfg_idx_e'(cfg_index_i))
        scl_pkg::CfgStopRadius:   stop_radius_q         <= cfg_data_i;
        scl_pkg::CfgCorridorHalf: corridor_half_width_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  scl_front u_front (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .in_item_i             (in_item_i),
    .corridor_half_width_i (corridor_half_width_q),
    .queue_status_i        (q_status),
    .push_o                (q_push),
    .cmd_o                 (q_wdata)
  );

  scl_cmd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .data_i   (q_wdata),
    .pop_i    (q_pop),
    .data_o   (q_rdata),
    .status_o (q_status)
  );

  scl_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .queue_status_i (q_status),
    .cmd_i          (q_rdata),
    .pop_o          (q_pop),
    .stop_radius_i  (stop_radius_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_item_o     (out_item_o)
  );

  // The classifier never pushes into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_status.full |-> !q_push)
    else $error("command pushed into a full queue");

  // The speed unit only takes a command that is there.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> !q_status.empty)
    else $error("command popped from an empty queue");

  // A stop radius write lands in its register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (cfg_valid_i && cfg_ready_o && cfg_index_i == scl_pkg::CfgStopRadius)
      |=> (stop_radius_q == $past(cfg_data_i)))
    else $error("stop radius write lost");

endmodule
